// ===== rtl/ordered_list_insert_remove_search_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list core
// Shared property wrappers; each expects clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_REMOVE_SEARCH_CORE_DEFINES_SVH
`define ORDERED_LIST_INSERT_REMOVE_SEARCH_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OLRS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OLRS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/olrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered list package
// Command and status codes, shift controls and the channel word formats.
// ----------------------------------------------------------------------------
package olrs_pkg;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_PUSH   = 3'd2,
    CMD_POP    = 3'd3,
    CMD_FIND   = 3'd4,
    CMD_READ   = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BOUNDS   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // What every cell of the row does at each clock edge.
  typedef enum logic [1:0] {
    SHIFT_NONE   = 2'd0,
    SHIFT_INSERT = 2'd1,
    SHIFT_REMOVE = 2'd2
  } shift_op_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [4:0]         position;
    logic signed [31:0] item_value;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] read_value;
    logic [3:0]         found_index;
    logic [4:0]         count;
  } rsp_word_t;

endpackage

// ===== rtl/olrs_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface olrs_cmd_if;
  logic                  valid;
  logic                  ready;
  olrs_pkg::cmd_word_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/olrs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one response word.
// ----------------------------------------------------------------------------
interface olrs_rsp_if;
  logic                  valid;
  logic                  ready;
  olrs_pkg::rsp_word_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/olrs_cell.sv =====
// ----------------------------------------------------------------------------
// Ordered list cell
// One list entry: loads, takes from a neighbour or holds, and compares.
// ----------------------------------------------------------------------------
module olrs_cell #(
  parameter int unsigned INDEX      = 0,
  parameter int unsigned IW         = 4,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                     clk_i,
  input  olrs_pkg::shift_op_e      op_i,
  input  logic [IW-1:0]            pos_i,
  input  logic [DATA_WIDTH-1:0]    value_i,
  input  logic [DATA_WIDTH-1:0]    left_i,
  input  logic [DATA_WIDTH-1:0]    right_i,
  output logic [DATA_WIDTH-1:0]    entry_o,
  output logic                     match_o
);

  localparam logic [IW-1:0] MyIdx = IW'(INDEX);

  logic [DATA_WIDTH-1:0] entry_q, entry_d;

  // Insert: the target cell loads, cells above it take from below.
  // Remove: the target cell and those above it take from above.
  always_comb begin
    entry_d = entry_q;
    case (op_i)
      olrs_pkg::SHIFT_INSERT: begin
        if (MyIdx == pos_i) begin
          entry_d = value_i;
        end else if (MyIdx > pos_i) begin
          entry_d = left_i;
        end
      end
      olrs_pkg::SHIFT_REMOVE: begin
        if (MyIdx >= pos_i) begin
          entry_d = right_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign match_o = (entry_q == value_i);

endmodule

// ===== rtl/olrs_prio_enc.sv =====
// ----------------------------------------------------------------------------
// Ordered list priority encoder
// Gives the lowest set position of the request vector.
// ----------------------------------------------------------------------------
module olrs_prio_enc #(
  parameter int unsigned N  = 16,
  parameter int unsigned IW = 4
) (
  input  logic [N-1:0]  req_i,
  output logic          found_o,
  output logic [IW-1:0] index_o
);

  always_comb begin
    index_o = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (req_i[i]) begin
        index_o = IW'(i);
      end
    end
  end

  assign found_o = |req_i;

endmodule

// ===== rtl/ordered_list_insert_remove_search_core.sv =====
// ----------------------------------------------------------------------------
// Ordered list insert, remove and search core
// Response: a command's response word is registered and shown in the cycle after it is taken.
// Throughput: one command per cycle while responses are drained; every cell shifts or compares at once.
// Reset: the entry count and response valid clear; entries are left as is.
// ----------------------------------------------------------------------------
`include "ordered_list_insert_remove_search_core_defines.svh"

module ordered_list_insert_remove_search_core #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  olrs_cmd_if.sink    cmd_i,
  olrs_rsp_if.source  rsp_o
);

  // Index width addresses a cell; count width holds the capacity itself.
  localparam int unsigned IW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > 5) ? CW : 5;

  // --------------------------------------------------------------------------
  // Handshake. The response register separates the two sides: a new command
  // is taken whenever the register is empty or is being drained this cycle.
  // --------------------------------------------------------------------------
  logic acc;
  logic rsp_valid_q, rsp_valid_d;
  olrs_pkg::rsp_word_t rsp_q, rsp_d;

  assign cmd_i.ready = !rsp_valid_q || rsp_o.ready;
  assign acc         = cmd_i.valid && cmd_i.ready;

  // --------------------------------------------------------------------------
  // The stored value is the low DATA_WIDTH bits of the item, zero extended
  // where the data path is wider than the channel.
  // --------------------------------------------------------------------------
  logic [DATA_WIDTH+31:0] val_ext;
  logic [DATA_WIDTH-1:0]  val_data;

  assign val_ext  = (DATA_WIDTH + 32)'($unsigned(cmd_i.payload.item_value));
  assign val_data = val_ext[DATA_WIDTH-1:0];

  // --------------------------------------------------------------------------
  // Row of cells. Each cell sees both neighbours, the broadcast shift
  // control and the broadcast value; the ends take zero from outside.
  // --------------------------------------------------------------------------
  logic [CW-1:0]            count_q, count_d;
  olrs_pkg::shift_op_e      shift_op;
  logic [IW-1:0]            shift_pos;
  logic [DATA_WIDTH-1:0]    entry   [CAPACITY];
  logic [DATA_WIDTH-1:0]    left_w  [CAPACITY];
  logic [DATA_WIDTH-1:0]    right_w [CAPACITY];
  logic [CAPACITY-1:0]      match_raw;
  logic [CAPACITY-1:0]      live;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_w[g] = '0;
    end else begin : g_left
      assign left_w[g] = entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w[g] = '0;
    end else begin : g_right
      assign right_w[g] = entry[g+1];
    end

    // Only entries below the count take part in a search.
    assign live[g] = (CW'(g) < count_q);

    olrs_cell #(
      .INDEX      (g),
      .IW         (IW),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (shift_op),
      .pos_i   (shift_pos),
      .value_i (val_data),
      .left_i  (left_w[g]),
      .right_i (right_w[g]),
      .entry_o (entry[g]),
      .match_o (match_raw[g])
    );
  end

  // Lowest live match wins.
  logic          found;
  logic [IW-1:0] found_ix;

  olrs_prio_enc #(
    .N  (CAPACITY),
    .IW (IW)
  ) u_prio_enc (
    .req_i   (match_raw & live),
    .found_o (found),
    .index_o (found_ix)
  );

  // --------------------------------------------------------------------------
  // Command decode. Emptiness is tested before bounds, and bounds before
  // fullness. Undefined command codes change nothing and report success.
  // --------------------------------------------------------------------------
  logic [CMPW-1:0]       pos_w, cnt_w;
  logic                  empty, full;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH+31:0] rd_ext;
  logic [IW+3:0]         fidx_ext;
  logic [CW+4:0]         cnt_ext;

  assign pos_w   = CMPW'(cmd_i.payload.position);
  assign cnt_w   = CMPW'(count_q);
  assign empty   = (count_q == '0);
  assign full    = (count_q == CW'(CAPACITY));
  assign rd_data = entry[pos_w[IW-1:0]];

  always_comb begin
    olrs_pkg::status_e st;
    olrs_pkg::shift_op_e op;
    logic [IW-1:0] spos;
    logic [CW-1:0] cnt_n;
    logic rd_ok;
    logic fd_ok;
    st    = olrs_pkg::ST_OK;
    op    = olrs_pkg::SHIFT_NONE;
    spos  = pos_w[IW-1:0];
    cnt_n = count_q;
    rd_ok = 1'b0;
    fd_ok = 1'b0;
    case (olrs_pkg::cmd_e'(cmd_i.payload.cmd))
      olrs_pkg::CMD_INSERT: begin
        if (pos_w > cnt_w) begin
          st = olrs_pkg::ST_BOUNDS;
        end else if (full) begin
          st = olrs_pkg::ST_FULL;
        end else begin
          op    = olrs_pkg::SHIFT_INSERT;
          cnt_n = count_q + 1'b1;
        end
      end
      olrs_pkg::CMD_PUSH: begin
        if (full) begin
          st = olrs_pkg::ST_FULL;
        end else begin
          // Not full, so the count fits an index.
          op    = olrs_pkg::SHIFT_INSERT;
          spos  = count_q[IW-1:0];
          cnt_n = count_q + 1'b1;
        end
      end
      olrs_pkg::CMD_REMOVE: begin
        if (empty) begin
          st = olrs_pkg::ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          st = olrs_pkg::ST_BOUNDS;
        end else begin
          op    = olrs_pkg::SHIFT_REMOVE;
          cnt_n = count_q - 1'b1;
        end
      end
      olrs_pkg::CMD_POP: begin
        // The tail entry simply drops out of range; no cell moves.
        if (empty) begin
          st = olrs_pkg::ST_EMPTY;
        end else begin
          cnt_n = count_q - 1'b1;
        end
      end
      olrs_pkg::CMD_FIND: begin
        if (found) begin
          fd_ok = 1'b1;
        end else begin
          st = olrs_pkg::ST_NOTFOUND;
        end
      end
      olrs_pkg::CMD_READ: begin
        if (empty) begin
          st = olrs_pkg::ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          st = olrs_pkg::ST_BOUNDS;
        end else begin
          rd_ok = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Nothing moves unless the command is actually taken.
    shift_op  = acc ? op : olrs_pkg::SHIFT_NONE;
    shift_pos = spos;
    count_d   = acc ? cnt_n : count_q;

    rd_ext   = (DATA_WIDTH + 32)'(rd_ok ? rd_data : '0);
    fidx_ext = (IW + 4)'(fd_ok ? found_ix : '0);
    cnt_ext  = (CW + 5)'(cnt_n);

    rsp_d.status      = st;
    rsp_d.read_value  = rd_ext[31:0];
    rsp_d.found_index = fidx_ext[3:0];
    rsp_d.count       = cnt_ext[4:0];
  end

  // --------------------------------------------------------------------------
  // Response register and entry count.
  // --------------------------------------------------------------------------
  always_comb begin
    if (acc) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `OLRS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(CAPACITY), "count above capacity")
  `OLRS_ASSERT_NEXT(a_grow, acc && (shift_op == olrs_pkg::SHIFT_INSERT), count_q == $past(count_q) + 1'b1, "insert did not grow list")
  `OLRS_ASSERT_NEXT(a_err_hold, acc && (rsp_d.status != olrs_pkg::ST_OK), $stable(count_q), "failed command changed count")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list core regression bench
// Sends command words through the valid/ready channel and keeps its own
// shadow copy of the list. Every response word is checked field by field
// against the shadow list, in order, while both sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned LIST_DEPTH  = 16;
  localparam int unsigned RANDOM_CMDS = 1030;
  localparam int unsigned QUIET_CMDS  = 150;   // final stretch with no idling
  localparam int unsigned HOLD_AT     = 300;   // where the long receiver stall starts
  localparam int unsigned HOLD_CYCLES = 48;
  localparam int unsigned DRAIN_AT    = 700;   // sender waits for all responses here

  // Command codes the block treats as no-ops; the package gives them no name.
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  typedef struct {
    olrs_pkg::cmd_word_t word;
    bit                  drain_first;  // hold this word back until nothing is outstanding
  } queued_cmd_t;

  logic clk;
  logic rst_n;

  olrs_cmd_if cmd_ch ();
  olrs_rsp_if rsp_ch ();

  ordered_list_insert_remove_search_core #(
    .CAPACITY   (LIST_DEPTH),
    .DATA_WIDTH (32)
  ) uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_ch),
    .rsp_o  (rsp_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Shadow list and the prediction of each response word.
  // --------------------------------------------------------------------------
  logic signed [31:0] shadow_list [LIST_DEPTH];
  int unsigned        shadow_len = 0;
  int unsigned        shadow_peak = 0;

  queued_cmd_t         pending_cmds [$];
  olrs_pkg::rsp_word_t expected_rsps [$];

  int unsigned err_count = 0;
  int unsigned cmds_taken = 0;
  int unsigned rsps_checked = 0;
  int unsigned quiet_from = '1;
  int unsigned status_seen [5];
  bit          cmd_fire = 1'b0;
  bit          rsp_hold = 1'b0;

  // Bounds come before fullness, so an insert past the tail of a full list
  // reports a bounds error rather than a full one.
  function automatic olrs_pkg::status_e shadow_insert(int unsigned pos,
                                                      logic signed [31:0] val);
    if (pos > shadow_len) return olrs_pkg::ST_BOUNDS;
    if (shadow_len >= LIST_DEPTH) return olrs_pkg::ST_FULL;
    for (int unsigned i = shadow_len; i > pos; i--) shadow_list[i] = shadow_list[i - 1];
    shadow_list[pos] = val;
    shadow_len++;
    if (shadow_len > shadow_peak) shadow_peak = shadow_len;
    return olrs_pkg::ST_OK;
  endfunction

  // An empty list is reported before any bounds check.
  function automatic olrs_pkg::status_e shadow_remove(int unsigned pos);
    if (shadow_len == 0) return olrs_pkg::ST_EMPTY;
    if (pos >= shadow_len) return olrs_pkg::ST_BOUNDS;
    for (int unsigned i = pos; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
    shadow_len--;
    return olrs_pkg::ST_OK;
  endfunction

  function automatic olrs_pkg::rsp_word_t predict_list_rsp(olrs_pkg::cmd_word_t w);
    olrs_pkg::rsp_word_t r;
    r = '0;
    r.status = olrs_pkg::ST_OK;
    case (w.cmd)
      olrs_pkg::CMD_INSERT: r.status = shadow_insert(w.position, w.item_value);
      olrs_pkg::CMD_REMOVE: r.status = shadow_remove(w.position);
      olrs_pkg::CMD_PUSH:   r.status = shadow_insert(shadow_len, w.item_value);
      olrs_pkg::CMD_POP: begin
        if (shadow_len == 0) r.status = olrs_pkg::ST_EMPTY;
        else r.status = shadow_remove(shadow_len - 1);
      end
      olrs_pkg::CMD_FIND: begin
        // Lowest matching index wins; an empty list simply finds nothing.
        r.status = olrs_pkg::ST_NOTFOUND;
        for (int unsigned i = 0; i < shadow_len; i++) begin
          if (shadow_list[i] == w.item_value) begin
            r.status = olrs_pkg::ST_OK;
            r.found_index = i[3:0];
            break;
          end
        end
      end
      olrs_pkg::CMD_READ: begin
        if (shadow_len == 0) r.status = olrs_pkg::ST_EMPTY;
        else if (w.position >= shadow_len) r.status = olrs_pkg::ST_BOUNDS;
        else r.read_value = shadow_list[w.position[3:0]];
      end
      default: ;  // spare codes leave the list alone and report success
    endcase
    r.count = shadow_len[4:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers. Values are drawn half the time from a small pool, so
  // that finds hit often and duplicates exercise the lowest-index rule.
  // --------------------------------------------------------------------------
  function automatic void queue_cmd(logic [2:0] c, logic [4:0] pos,
                                    logic signed [31:0] val, bit drain = 1'b0);
    queued_cmd_t q;
    q.word.cmd        = c;
    q.word.position   = pos;
    q.word.item_value = val;
    q.drain_first     = drain;
    pending_cmds.push_back(q);
  endfunction

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] pool [8];
    pool = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sd1,
             32'sd5, 32'sd42, -32'sd1000, 32'sh5555_AAAA};
    if ($urandom_range(0, 1) == 0) return pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  // Mostly in-range positions, with the whole five-bit range now and then.
  function automatic logic [4:0] pick_position();
    if ($urandom_range(0, 9) == 0) return 5'($urandom_range(0, 31));
    return 5'($urandom_range(0, LIST_DEPTH));
  endfunction

  // Growing phases favour insert and push so the list reaches full; shrinking
  // phases favour remove and pop so it drains back to empty.
  function automatic logic [2:0] pick_cmd(bit growing);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) return ($urandom_range(0, 1) != 0) ? CMD_SPARE_7 : CMD_SPARE_6;
    if (roll < 14) return olrs_pkg::CMD_FIND;
    if (roll < 24) return olrs_pkg::CMD_READ;
    if (growing) begin
      if (roll < 60) return olrs_pkg::CMD_INSERT;
      if (roll < 88) return olrs_pkg::CMD_PUSH;
      if (roll < 95) return olrs_pkg::CMD_REMOVE;
      return olrs_pkg::CMD_POP;
    end
    if (roll < 60) return olrs_pkg::CMD_REMOVE;
    if (roll < 88) return olrs_pkg::CMD_POP;
    if (roll < 95) return olrs_pkg::CMD_INSERT;
    return olrs_pkg::CMD_PUSH;
  endfunction

  function automatic bit idling_allowed();
    return (cmds_taken < quiet_from) && ((cmds_taken / 64) % 4 != 3);
  endfunction

  // --------------------------------------------------------------------------
  // Command driver: changes the channel on the falling edge. A word on the bus
  // stays until the rising edge takes it; then the next one, a gap, or a wait
  // for the pipeline to drain follows.
  // --------------------------------------------------------------------------
  int unsigned send_gap = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      cmd_ch.valid <= 1'b0;
    end else if (cmd_ch.valid && !cmd_fire) begin
      // still waiting for the block to take the current word
    end else if (send_gap > 0) begin
      cmd_ch.valid <= 1'b0;
      send_gap--;
    end else if (pending_cmds.size() == 0) begin
      cmd_ch.valid <= 1'b0;
    end else if (pending_cmds[0].drain_first && expected_rsps.size() != 0) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      cmd_ch.payload <= pending_cmds[0].word;
      cmd_ch.valid   <= 1'b1;
      pending_cmds.pop_front();
      if (idling_allowed() && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 3);
    end
  end

  // Response receiver: random stalls, plus the long hold-off from its own
  // process below while the sender keeps offering words.
  int unsigned rcv_gap = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else if (rsp_hold) begin
      rsp_ch.ready <= 1'b0;
    end else if (rcv_gap > 0) begin
      rsp_ch.ready <= 1'b0;
      rcv_gap--;
    end else begin
      rsp_ch.ready <= 1'b1;
      if (idling_allowed() && $urandom_range(0, 7) == 0) rcv_gap = $urandom_range(1, 3);
    end
  end

  initial begin
    while (cmds_taken < HOLD_AT) @(negedge clk);
    rsp_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rsp_hold = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Monitor: samples both channels on the rising edge. The response is checked
  // first; since the response word is registered, it can never belong to the word taken
  // at the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    olrs_pkg::rsp_word_t exp_rsp;
    olrs_pkg::rsp_word_t act_rsp;
    cmd_fire = 1'b0;
    if (rst_n) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        act_rsp = rsp_ch.payload;
        if (expected_rsps.size() == 0) begin
          $error("response word with nothing outstanding: %p", act_rsp);
          err_count++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          rsps_checked++;
          if (act_rsp.status <= olrs_pkg::ST_NOTFOUND) status_seen[act_rsp.status]++;
          if (act_rsp.status !== exp_rsp.status) begin
            $error("status: expected %0d, actual %0d", exp_rsp.status, act_rsp.status);
            err_count++;
          end
          if (act_rsp.read_value !== exp_rsp.read_value) begin
            $error("read_value: expected %0d, actual %0d",
                   exp_rsp.read_value, act_rsp.read_value);
            err_count++;
          end
          if (act_rsp.found_index !== exp_rsp.found_index) begin
            $error("found_index: expected %0d, actual %0d",
                   exp_rsp.found_index, act_rsp.found_index);
            err_count++;
          end
          if (act_rsp.count !== exp_rsp.count) begin
            $error("count: expected %0d, actual %0d", exp_rsp.count, act_rsp.count);
            err_count++;
          end
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        cmd_fire = 1'b1;
        cmds_taken++;
        expected_rsps.push_back(predict_list_rsp(cmd_ch.payload));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // --------------------------------------------------------------------------
  initial begin
    bit growing;
    int unsigned total;
    cmd_ch.valid   = 1'b0;
    cmd_ch.payload = '0;
    rsp_ch.ready   = 1'b0;
    rst_n          = 1'b0;

    // Directed opening: every command on an empty list, the extreme values,
    // inserts at head, middle and tail, a duplicate for find, every kind of
    // out-of-bounds request, and the spare command codes.
    queue_cmd(olrs_pkg::CMD_POP,    5'd0,  32'sd0);
    queue_cmd(olrs_pkg::CMD_REMOVE, 5'd0,  32'sd0);
    queue_cmd(olrs_pkg::CMD_READ,   5'd0,  32'sd0);
    queue_cmd(olrs_pkg::CMD_FIND,   5'd0,  32'sd0);
    queue_cmd(olrs_pkg::CMD_INSERT, 5'd1,  32'sd9);
    queue_cmd(olrs_pkg::CMD_PUSH,   5'd31, 32'sh7FFF_FFFF);
    queue_cmd(olrs_pkg::CMD_PUSH,   5'd0,  32'sh8000_0000);
    queue_cmd(olrs_pkg::CMD_INSERT, 5'd0,  32'sd0);
    queue_cmd(olrs_pkg::CMD_INSERT, 5'd1,  -32'sd1);
    queue_cmd(olrs_pkg::CMD_INSERT, 5'd4,  32'sh7FFF_FFFF);
    queue_cmd(olrs_pkg::CMD_FIND,   5'd7,  32'sh7FFF_FFFF);
    queue_cmd(olrs_pkg::CMD_FIND,   5'd0,  32'sd12345);
    queue_cmd(olrs_pkg::CMD_READ,   5'd4,  32'sd0);
    queue_cmd(olrs_pkg::CMD_READ,   5'd5,  32'sd0);
    queue_cmd(olrs_pkg::CMD_READ,   5'd31, -32'sd1);
    queue_cmd(olrs_pkg::CMD_REMOVE, 5'd5,  32'sd0);
    queue_cmd(olrs_pkg::CMD_INSERT, 5'd31, 32'sd77);
    queue_cmd(olrs_pkg::CMD_REMOVE, 5'd1,  32'sd0);
    queue_cmd(CMD_SPARE_6,          5'd31, -32'sd1);
    queue_cmd(CMD_SPARE_7,          5'd0,  32'sh8000_0000);
    queue_cmd(olrs_pkg::CMD_POP,    5'd0,  32'sd0);
    queue_cmd(olrs_pkg::CMD_REMOVE, 5'd0,  32'sd0);

    // Random part in alternating growing and shrinking phases of 60 words,
    // so the list swings between full and empty many times over.
    growing = 1'b1;
    for (int unsigned n = 0; n < RANDOM_CMDS; n++) begin
      if (n % 60 == 0 && n != 0) growing = !growing;
      queue_cmd(pick_cmd(growing), pick_position(), pick_value(), pending_cmds.size() == DRAIN_AT);
    end
    total      = pending_cmds.size();
    quiet_from = total - QUIET_CMDS;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_cmds.size() != 0 || cmd_ch.valid) @(posedge clk);
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Covered %0d commands and %0d checked response words; list peaked at %0d.",
             cmds_taken, rsps_checked, shadow_peak);
    $display("Responses by status: ok %0d, bounds %0d, empty %0d, full %0d, not found %0d.",
             status_seen[olrs_pkg::ST_OK], status_seen[olrs_pkg::ST_BOUNDS],
             status_seen[olrs_pkg::ST_EMPTY], status_seen[olrs_pkg::ST_FULL],
             status_seen[olrs_pkg::ST_NOTFOUND]);
    if (err_count == 0) begin
      $display("ordered_list_insert_remove_search_core regression: pass");
    end else begin
      $display("ordered_list_insert_remove_search_core regression: fail");
    end
    $finish;
  end

  // Watchdog, many times the slowest legal run.
  initial begin
    #2ms;
    $display("ordered_list_insert_remove_search_core regression: fail");
    $finish;
  end

endmodule
